FILE: rtl/core/pba_pkg.sv
// Package for the page bitmap allocator: sizes, request and status codes,
// the configuration register indexes, the write-port struct and the tail-mask helper.
// It has no dependencies and is imported by every module of the block.
`default_nettype none

package pba_pkg;

   localparam int PAGES     = 512;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int BM_WORDS  = (PAGES + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = $clog2(BM_WORDS);
   localparam int PG_W      = 9;
   localparam int CNT_W     = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Field placement inside rsp_tdata, lowest bit first.
   localparam int RSP_PAGE_LSB  = 0;
   localparam int RSP_COUNT_LSB = PG_W;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_INIT  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NONE   = 2'd1,
      ST_BEYOND = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;

   localparam logic CSR_LAST_OS_PAGE = 1'b0;
   localparam logic CSR_HIGHEST_PAGE = 1'b1;

   typedef struct packed {
      logic              en;
      logic [WIDX_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } bm_write_type;

   // Bits of a bitmap word that stand for real pages (all of them unless
   // the page count is not a whole number of words).
   function automatic logic [WORD_W-1:0] word_valid_mask(input logic [WIDX_W-1:0] widx);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if ((int'(widx) * WORD_W + b) < PAGES) begin
            mask[b] = 1'b1;
         end
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pba_bitmap.sv
// Free-page bitmap storage: one word per row, one read and one write port.
// Depends on pba_pkg for sizes and the write-port struct.
`default_nettype none

module pba_bitmap
   import pba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [WIDX_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data,
   input  wire bm_write_type      wr
);

   logic [WORD_W-1:0] words_ff [BM_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BM_WORDS; i++) begin
            words_ff[i] <= '0;
         end
      end else if (wr.en) begin
         words_ff[wr.addr] <= wr.data;
      end
   end

   assign rd_data = words_ff[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/core/pba_ffs.sv
// Find-first-set unit: lowest set bit of one bitmap word.
// Depends on pba_pkg for the word width.
`default_nettype none

module pba_ffs
   import pba_pkg::*;
(
   input  wire logic [WORD_W-1:0] word,
   output logic                   found,
   output logic      [BIT_W-1:0]  bit_idx
);

   always_comb begin
      found   = 1'b0;
      bit_idx = '0;
      // Walk from the top so that the lowest set bit wins.
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (word[b]) begin
            found   = 1'b1;
            bit_idx = BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/pba_seq.sv
// Request sequencer: scans, updates and refills the bitmap one word a cycle,
// keeps the free count and the configuration registers, and owns the result register.
// Depends on pba_pkg and pba_ffs; drives the pba_bitmap write port.
`default_nettype none

module pba_seq
   import pba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_addr,
   input  wire logic [PG_W-1:0]   csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic [PG_W-1:0]   req_page,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [1:0]        rsp_status,
   output logic      [PG_W-1:0]   rsp_page,
   output logic      [CNT_W-1:0]  rsp_count,
   output logic      [WIDX_W-1:0] bm_rd_addr,
   input  wire logic [WORD_W-1:0] bm_rd_data,
   output bm_write_type           bm_wr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_FILL,
      S_DONE
   } state_type;

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(BM_WORDS - 1);
   localparam logic [CNT_W-1:0]  PAGES_CNT = CNT_W'(PAGES);

   state_type         state_ff, state_in;
   logic [WIDX_W-1:0] idx_ff, idx_in;
   logic [PG_W-1:0]   page_ff, page_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PG_W-1:0]   last_os_ff;
   logic [PG_W-1:0]   highest_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PG_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              ffs_found;
   logic [BIT_W-1:0]  ffs_bit;
   logic [PG_W-1:0]   found_page;
   logic [WORD_W-1:0] fill_word;
   logic [CNT_W-BIT_W-1:0] start_word;
   logic [CNT_W-BIT_W-1:0] cur_word;
   logic              req_fire;
   logic              rsp_free;

   pba_ffs u_ffs (
      .word    (bm_rd_data),
      .found   (ffs_found),
      .bit_idx (ffs_bit)
   );

   assign found_page = {idx_ff, ffs_bit};
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign bm_rd_addr = (state_ff == S_FREE) ? page_ff[PG_W-1:BIT_W] : idx_ff;

   // Refill word: pages below the start word are used, pages above it free,
   // and the start word itself is split at the first free page.
   assign start_word = start_ff[CNT_W-1:BIT_W];
   assign cur_word   = (CNT_W-BIT_W)'(idx_ff);
   always_comb begin
      if (cur_word < start_word) begin
         fill_word = '0;
      end else if (cur_word > start_word) begin
         fill_word = '1;
      end else begin
         fill_word = '1 << start_ff[BIT_W-1:0];
      end
      fill_word = fill_word & word_valid_mask(idx_ff);
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      page_in       = page_ff;
      status_in     = status_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_count_in  = rsp_count_ff;
      bm_wr.en      = 1'b0;
      bm_wr.addr    = bm_rd_addr;
      bm_wr.data    = bm_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in    = '0;
               page_in   = '0;
               status_in = ST_OK;
               case (req_kind)
                  REQ_ALLOC: begin
                     if (count_ff == '0) begin
                        status_in = ST_NONE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_FREE: begin
                     if (CNT_W'(req_page) < PAGES_CNT) begin
                        page_in  = req_page;
                        state_in = S_FREE;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  REQ_INIT: begin
                     start_in = CNT_W'(last_os_ff) + CNT_W'(1);
                     state_in = S_FILL;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (ffs_found) begin
               bm_wr.en   = 1'b1;
               bm_wr.data = bm_rd_data & ~(WORD_W'(1) << ffs_bit);
               count_in   = count_ff - CNT_W'(1);
               page_in    = found_page;
               status_in  = (found_page > highest_ff) ? ST_BEYOND : ST_OK;
               state_in   = S_DONE;
            end else if (idx_ff == LAST_WORD) begin
               // Count was nonzero but no bit is set: nothing to hand out.
               status_in = ST_NONE;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_ff + WIDX_W'(1);
            end
         end
         S_FREE: begin
            bm_wr.en   = 1'b1;
            bm_wr.data = bm_rd_data | (WORD_W'(1) << page_ff[BIT_W-1:0]);
            if (count_ff < PAGES_CNT) begin
               count_in = count_ff + CNT_W'(1);
            end
            page_in  = '0;
            state_in = S_DONE;
         end
         S_FILL: begin
            bm_wr.en   = 1'b1;
            bm_wr.addr = idx_ff;
            bm_wr.data = fill_word;
            if (idx_ff == LAST_WORD) begin
               count_in = (start_ff < PAGES_CNT) ? (PAGES_CNT - start_ff) : '0;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + WIDX_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = page_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_os_ff   <= '0;
         highest_ff   <= PG_W'(511);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_LAST_OS_PAGE: last_os_ff <= csr_wdata;
               CSR_HIGHEST_PAGE: highest_ff <= csr_wdata;
               default:          ;
            endcase
         end
      end
      idx_ff        <= idx_in;
      page_ff       <= page_in;
      status_ff     <= status_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_page   = rsp_page_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

FILE: rtl/core/page_bitmap_allocator_core.sv
// Page bitmap allocator. An allocate scans the bitmap word by word with the find-first unit
// up to the first word with a free page, then loads the result; a zero free count and other
// requests load it directly. A free of a valid page updates one word, an init rewrites every
// word first. One request at a time, taken the cycle after the previous result is loaded;
// a finished request waits while an earlier result is not taken.
// Synchronous reset clears the bitmap and count, sets last_os_page 0 and highest_page 511.
`default_nettype none

module page_bitmap_allocator_core
   import pba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_addr,
   input  wire logic [PG_W-1:0]       csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [8:0] free_page, rest zero
   input  wire logic [1:0]            req_tuser,   // [1:0] req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [8:0] page, [18:9] free_count
   output logic      [1:0]            rsp_tuser    // [1:0] status
);

   logic [WIDX_W-1:0] bm_rd_addr;
   logic [WORD_W-1:0] bm_rd_data;
   bm_write_type      bm_wr;
   logic [PG_W-1:0]   rsp_page;
   logic [CNT_W-1:0]  rsp_count;

   pba_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data),
      .wr      (bm_wr)
   );

   pba_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_page   (req_tdata[PG_W-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_page   (rsp_page),
      .rsp_count  (rsp_count),
      .bm_rd_addr (bm_rd_addr),
      .bm_rd_data (bm_rd_data),
      .bm_wr      (bm_wr)
   );

   assign rsp_tdata = {(RSP_DATA_W - PG_W - CNT_W)'(0), rsp_count, rsp_page};

endmodule

`default_nettype wire

FILE: rtl/core/pba_checker.sv
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg for codes and field positions.
`default_nettype none

module pba_checker
   import pba_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   logic [PG_W-1:0]  chk_page;
   logic [CNT_W-1:0] chk_count;

   assign chk_page  = rsp_tdata[RSP_PAGE_LSB +: PG_W];
   assign chk_count = rsp_tdata[RSP_COUNT_LSB +: CNT_W];

   // A result that is not taken must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A request keeps the block busy for at least the following cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one was in progress");

   a_none_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NONE) |-> (chk_page == '0))
      else $error("no-free-page result carries a page number");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chk_count <= CNT_W'(PAGES)))
      else $error("free count above the page total");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != ST_RSVD))
      else $error("reserved status code on the result");

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_bitmap_allocator_core: directed and random requests with
// a predictor that tracks the bitmap and free count; random idling on both stream sides.
// Depends on pba_pkg and the core module only.
`default_nettype none

module tb_top;
   import pba_pkg::*;

   typedef struct {
      status_type        status;
      logic [PG_W-1:0]   page;
      logic [CNT_W-1:0]  count;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic                  csr_addr;
   logic [PG_W-1:0]       csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // Predicted state of the allocator.
   logic [WORD_W-1:0] page_map [BM_WORDS];
   int                free_total;
   int                os_limit;
   int                top_page;

   outcome_type       pending_outcomes [$];
   logic [PG_W-1:0]   taken_pages [$];
   int                error_count = 0;
   bit                req_idle_on = 1'b1;
   bit                rsp_idle_on = 1'b1;
   int                rsp_hold_cycles = 0;

   page_bitmap_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic outcome_type predict_outcome(input req_kind_type kind,
                                                   input logic [PG_W-1:0] pg);
      outcome_type res;
      int          first;
      res.status = ST_OK;
      res.page   = '0;
      first      = -1;
      case (kind)
         REQ_ALLOC: begin
            if (free_total != 0) begin
               for (int p = 0; p < PAGES && first < 0; p++) begin
                  if (page_map[p / WORD_W][p % WORD_W]) first = p;
               end
            end
            // A non-zero count with an empty bitmap leaves the count as it is.
            if (first < 0) begin
               res.status = ST_NONE;
            end else begin
               page_map[first / WORD_W][first % WORD_W] = 1'b0;
               free_total--;
               res.page   = PG_W'(first);
               res.status = (first > top_page) ? ST_BEYOND : ST_OK;
               taken_pages.push_back(PG_W'(first));
            end
         end
         REQ_FREE: begin
            if (int'(pg) < PAGES) begin
               page_map[pg / WORD_W][pg % WORD_W] = 1'b1;
               if (free_total < PAGES) free_total++;
            end
         end
         REQ_INIT: begin
            for (int p = 0; p < PAGES; p++) begin
               page_map[p / WORD_W][p % WORD_W] = (p > os_limit);
            end
            free_total = (os_limit + 1 < PAGES) ? PAGES - os_limit - 1 : 0;
            taken_pages.delete();
         end
         default: ;
      endcase
      res.count = CNT_W'(free_total);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_response
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request pending", int'(rsp_tuser), 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", int'(rsp_tuser), int'(want.status));
            if (rsp_tdata[RSP_PAGE_LSB +: PG_W] != want.page)
               report_mismatch("page", int'(rsp_tdata[RSP_PAGE_LSB +: PG_W]),
                               int'(want.page));
            if (rsp_tdata[RSP_COUNT_LSB +: CNT_W] != want.count)
               report_mismatch("free_count", int'(rsp_tdata[RSP_COUNT_LSB +: CNT_W]),
                               int'(want.count));
         end
      end
   end

   // Response side pacing; a requested hold-off is served here, cycle by cycle.
   initial begin : response_pacing
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_request(input req_kind_type kind, input logic [PG_W-1:0] pg);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(pg);
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(predict_outcome(kind, pg));
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes both registers, last_os_page first; only called while the block is idle.
   task automatic set_limits(input int os_value, input int top_value);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LAST_OS_PAGE;
      csr_wdata <= PG_W'(os_value);
      @(posedge clock);
      csr_addr  <= CSR_HIGHEST_PAGE;
      csr_wdata <= PG_W'(top_value);
      @(posedge clock);
      csr_we    <= 1'b0;
      os_limit = os_value;
      top_page = top_value;
   endtask

   // Mostly allocations and frees of pages handed out earlier, with some noise.
   task automatic random_request;
      int              roll;
      int              idx;
      logic [PG_W-1:0] pg;
      roll = $urandom_range(0, 99);
      pg   = PG_W'($urandom_range(0, PAGES - 1));
      if (roll < 50) begin
         send_request(REQ_ALLOC, pg);
      end else if (roll < 88) begin
         if (roll < 75 && taken_pages.size() > 0) begin
            idx = $urandom_range(0, taken_pages.size() - 1);
            pg  = taken_pages[idx];
            taken_pages.delete(idx);
         end
         send_request(REQ_FREE, pg);
      end else if (roll < 94) begin
         send_request(REQ_INIT, pg);
      end else begin
         send_request(REQ_NONE, pg);
      end
   endtask

   task automatic test_after_reset;
      // The bitmap starts empty, so nothing can be allocated until a page is freed.
      send_request(REQ_ALLOC, '0);
      send_request(REQ_NONE, '1);
      send_request(REQ_FREE, '0);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_ALLOC, '0);
      wait_drained();
   endtask

   task automatic test_init_extremes;
      // All pages belong to the OS image: init leaves no free page.
      set_limits(511, 511);
      send_request(REQ_INIT, '0);
      send_request(REQ_ALLOC, '0);
      wait_drained();
      // One free page, freed twice, so the count runs ahead of the bitmap.
      set_limits(510, 511);
      send_request(REQ_INIT, '0);
      send_request(REQ_FREE, 9'd511);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_ALLOC, '0);
      wait_drained();
      // The count saturates at the page total.
      set_limits(0, 511);
      send_request(REQ_INIT, '0);
      send_request(REQ_FREE, '0);
      send_request(REQ_FREE, '0);
      send_request(REQ_ALLOC, '0);
      wait_drained();
   endtask

   task automatic test_beyond_memory;
      set_limits(0, 0);
      send_request(REQ_INIT, '0);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 9'd1);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 9'd511);
      wait_drained();
   endtask

   task automatic test_backpressure;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_limits(400, 511);
      rsp_hold_cycles = 300;
      send_request(REQ_INIT, '0);
      repeat (24) random_request();
      wait_drained();
   endtask

   task automatic test_random_traffic;
      int os_value;
      int top_value;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin os_value = 0;   top_value = 511; end
            1: begin os_value = 510; top_value = 511; end
            2: begin os_value = 511; top_value = 0;   end
            3: begin os_value = 480; top_value = 300; end
            4: begin os_value = 255; top_value = 256; end
            default: begin
               os_value  = $urandom_range(0, 511);
               top_value = $urandom_range(0, 511);
            end
         endcase
         req_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         rsp_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         set_limits(os_value, top_value);
         send_request(REQ_INIT, '0);
         repeat (52) random_request();
         wait_drained();
      end
   endtask

   initial begin
      csr_we     <= 1'b0;
      csr_addr   <= CSR_LAST_OS_PAGE;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_ALLOC;
      for (int w = 0; w < BM_WORDS; w++) page_map[w] = '0;
      free_total = 0;
      os_limit   = 0;
      top_page   = 511;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_init_extremes();
      test_beyond_memory();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
